>>> rtl/stt_pkg.sv
// stt_pkg: shared types and constants of the source text tokenizer
// no dependencies; used by stt_scan, stt_result_buf and source_text_tokenizer
`default_nettype none

package stt_pkg;

    // result kinds
    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_CHAR  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // token types
    localparam logic [3:0] T_INT    = 4'd0;
    localparam logic [3:0] T_FLOAT  = 4'd1;
    localparam logic [3:0] T_STRING = 4'd2;
    localparam logic [3:0] T_WORD   = 4'd3;
    localparam logic [3:0] T_LPAREN = 4'd4;
    localparam logic [3:0] T_RPAREN = 4'd5;
    localparam logic [3:0] T_LBRACE = 4'd6;
    localparam logic [3:0] T_RBRACE = 4'd7;
    localparam logic [3:0] T_COLON  = 4'd8;
    localparam logic [3:0] T_ARROW  = 4'd9;
    localparam logic [3:0] T_EOF    = 4'd10;

    // error codes
    localparam logic ERR_ESCAPE = 1'b0;
    localparam logic ERR_UNTERM = 1'b1;

    // input opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;

    // results one input item can cause, at most
    localparam int MAX_RES = 4;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  token_type;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic [31:0] token_line;
        logic [63:0] int_value;
        logic [7:0]  char_value;
        logic        error_code;
    } result_t;

    typedef struct packed {
        logic [2:0]               count;
        result_t [MAX_RES-1:0]    res;
    } batch_t;

endpackage

`default_nettype wire

>>> rtl/source_text_tokenizer.sv
// source_text_tokenizer: top level, input register, scanner and result buffer
// depends on stt_pkg, stt_scan, stt_result_buf
//
//  channel | fields                                   | accepted when
//  s_      | tuser: opcode; tdata: src_byte           | s_tvalid && s_tready
//  m_      | tuser: kind; tdata: type..error; tlast   | m_tvalid && m_tready
//
// one item per cycle while the result side keeps up: an item goes input register -> scanner step -> result register
// an item causing several results holds the input side until its last result is taken (one result a transfer)
// synchronous active-low reset returns the scanner to line 1, offset 0, not halted
// a stalled result side keeps the next item in the input register; tready drops after that
`default_nettype none

module source_text_tokenizer
    import stt_pkg::*;
#(
    parameter int POS_BITS  = 32,
    parameter int LINE_BITS = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] src_byte
    input  wire logic         s_tuser,   // [0] opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [175:0]      m_tdata,   // [3:0] token_type, [35:4] token_start,
                                         // [67:36] token_length, [99:68] token_line,
                                         // [163:100] int_value, [171:164] char_value,
                                         // [172] error_code
    output logic [1:0]        m_tuser,   // [1:0] kind
    output logic              m_tlast    // last_of_run
);

    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;
    logic       can_load;
    logic       fire;
    batch_t     batch;

    assign fire     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    stt_scan #(
        .POS_BITS  (POS_BITS),
        .LINE_BITS (LINE_BITS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire     (fire),
        .op       (in_op_reg),
        .src_byte (in_byte_reg),
        .batch    (batch)
    );

    stt_result_buf u_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .batch    (batch),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/stt_scan.sv
// stt_scan: scanner state and the step logic, of up to three passes, for one item
// depends on stt_pkg
`default_nettype none

module stt_scan
    import stt_pkg::*;
#(
    parameter int POS_BITS  = 32,
    parameter int LINE_BITS = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       fire,
    input  wire logic       op,
    input  wire logic [7:0] src_byte,
    output batch_t          batch
);

    typedef enum logic [3:0] {
        M_IDLE, M_MINUS, M_INT, M_FRAC, M_EXP0, M_EXP1, M_EXPD, M_WORD, M_STR, M_ESC
    } mode_t;

    localparam int F_NEG  = 0;
    localparam int F_OVF  = 1;
    localparam int F_FRAC = 2;
    localparam int F_EXP  = 3;

    mode_t                mode_reg, mode_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0]  start_reg, start_next;
    logic [LINE_BITS-1:0] tline_reg, tline_next;
    logic [63:0]          accum_reg, accum_next;
    logic [3:0]           flags_reg, flags_next;
    logic [1:0]           held_reg, held_next;
    logic                 halted_reg, halted_next;

    function automatic logic [31:0] pos32(input logic [POS_BITS-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[31:0];
    endfunction

    function automatic logic [31:0] line32(input logic [LINE_BITS-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[31:0];
    endfunction

    function automatic logic is_ws(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic logic is_stop(input logic [7:0] b);
        return is_ws(b) || b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACE ||
               b == CH_RBRACE || b == CH_QUOTE || b == CH_COLON;
    endfunction

    // accumulate one decimal digit; top bit flags overflow
    function automatic logic [64:0] add_digit(input logic [63:0] acc, input logic neg,
                                              input logic ovf, input logic [7:0] b);
        logic [67:0] t;
        logic [67:0] lim;
        logic [64:0] r;
        t = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + 68'(b - CH_ZERO);
        lim = neg ? 68'h0_8000_0000_0000_0000 : 68'h0_7fff_ffff_ffff_ffff;
        if (ovf || t > lim) begin
            r = {1'b1, acc};
        end else begin
            r = {1'b0, t[63:0]};
        end
        return r;
    endfunction

    function automatic result_t mk(input logic [1:0] kind, input logic [3:0] tt,
                                   input logic [31:0] st, input logic [31:0] len,
                                   input logic [31:0] ln, input logic [63:0] iv,
                                   input logic [7:0] ch, input logic err);
        result_t r;
        r.kind = kind;
        r.token_type = tt;
        r.token_start = st;
        r.token_length = len;
        r.token_line = ln;
        r.int_value = iv;
        r.char_value = ch;
        r.error_code = err;
        return r;
    endfunction

    // step logic: new state and the results of one item
    always_comb begin
        logic [POS_BITS-1:0] p;
        logic [POS_BITS-1:0] len;
        logic [64:0]         ad;
        logic                go;
        logic                ch_ok;
        logic [7:0]          ch;
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        start_next  = start_reg;
        tline_next  = tline_reg;
        accum_next  = accum_reg;
        flags_next  = flags_reg;
        held_next   = held_reg;
        halted_next = halted_reg;
        batch       = '0;
        p           = pos_reg;
        len         = '0;
        ad          = '0;
        go          = 1'b0;
        ch_ok       = 1'b0;
        ch          = '0;

        if (fire && !halted_reg) begin
            if (op == OP_BYTE) begin
                pos_next = pos_reg + 1'b1;
            end

            // exponent without digits: number ends, held bytes restart a word
            if ((mode_next == M_EXP0 || mode_next == M_EXP1) &&
                (op == OP_END || !(is_digit(src_byte) ||
                 (mode_next == M_EXP0 && (src_byte == CH_PLUS || src_byte == CH_MINUS))))) begin
                len = p - POS_BITS'(held_next) - start_next;
                if (flags_next[F_OVF] || flags_next[F_FRAC] || flags_next[F_EXP]) begin
                    batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_FLOAT, pos32(start_next),
                        pos32(len), line32(tline_next), '0, '0, 1'b0);
                end else begin
                    batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_INT, pos32(start_next),
                        pos32(len), line32(tline_next),
                        flags_next[F_NEG] ? 64'd0 - accum_next : accum_next, '0, 1'b0);
                end
                batch.count = batch.count + 1'b1;
                start_next = p - POS_BITS'(held_next);
                tline_next = line_next;
                flags_next = '0;
                accum_next = '0;
                held_next  = '0;
                mode_next  = M_WORD;
            end

            if (op == OP_END) begin
                // close the open token, then end of file; an open string instead gives an error and halts
                case (mode_next)
                    M_MINUS, M_WORD: begin
                        batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_WORD, pos32(start_next),
                            pos32(p - start_next), line32(tline_next), '0, '0, 1'b0);
                        batch.count = batch.count + 1'b1;
                    end
                    M_INT, M_FRAC, M_EXPD: begin
                        len = p - start_next;
                        if (flags_next[F_OVF] || flags_next[F_FRAC] || flags_next[F_EXP]) begin
                            batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_FLOAT,
                                pos32(start_next), pos32(len), line32(tline_next), '0, '0, 1'b0);
                        end else begin
                            batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_INT,
                                pos32(start_next), pos32(len), line32(tline_next),
                                flags_next[F_NEG] ? 64'd0 - accum_next : accum_next, '0, 1'b0);
                        end
                        batch.count = batch.count + 1'b1;
                    end
                    M_STR, M_ESC: begin
                        batch.res[batch.count[1:0]] = mk(KIND_ERROR, T_STRING, pos32(start_next),
                            '0, line32(tline_next), '0, '0, ERR_UNTERM);
                        batch.count = batch.count + 1'b1;
                        halted_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
                if (!halted_next) begin
                    batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_EOF, pos32(p), '0,
                        line32(line_next), '0, '0, 1'b0);
                    batch.count = batch.count + 1'b1;
                    mode_next  = M_IDLE;
                    pos_next   = '0;
                    line_next  = LINE_BITS'(1);
                    start_next = '0;
                    tline_next = LINE_BITS'(1);
                    accum_next = '0;
                    flags_next = '0;
                    held_next  = '0;
                end
            end else begin
                // byte: up to three passes as a token closes and the byte restarts
                go = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    if (go) begin
                        case (mode_next)
                            M_IDLE: begin
                                go = 1'b0;
                                if (is_ws(src_byte)) begin
                                    if (src_byte == CH_LF && line_next != '1) begin
                                        line_next = line_next + 1'b1;
                                    end
                                end else if (src_byte == CH_LPAREN || src_byte == CH_RPAREN ||
                                             src_byte == CH_LBRACE || src_byte == CH_RBRACE ||
                                             src_byte == CH_COLON) begin
                                    batch.res[batch.count[1:0]] = mk(KIND_TOKEN,
                                        src_byte == CH_LPAREN ? T_LPAREN :
                                        src_byte == CH_RPAREN ? T_RPAREN :
                                        src_byte == CH_LBRACE ? T_LBRACE :
                                        src_byte == CH_RBRACE ? T_RBRACE : T_COLON,
                                        pos32(p), 32'd1, line32(line_next), '0, '0, 1'b0);
                                    batch.count = batch.count + 1'b1;
                                end else begin
                                    tline_next = line_next;
                                    if (src_byte == CH_QUOTE) begin
                                        start_next = p + 1'b1;
                                        mode_next  = M_STR;
                                    end else begin
                                        start_next = p;
                                        flags_next = '0;
                                        accum_next = '0;
                                        if (is_digit(src_byte)) begin
                                            ad = add_digit(64'd0, 1'b0, 1'b0, src_byte);
                                            flags_next[F_OVF] = ad[64];
                                            accum_next = ad[63:0];
                                            mode_next = M_INT;
                                        end else begin
                                            mode_next = (src_byte == CH_MINUS) ? M_MINUS : M_WORD;
                                        end
                                    end
                                end
                            end
                            M_MINUS: begin
                                if (is_digit(src_byte)) begin
                                    go = 1'b0;
                                    flags_next = '0;
                                    flags_next[F_NEG] = 1'b1;
                                    ad = add_digit(accum_next, 1'b1, 1'b0, src_byte);
                                    flags_next[F_OVF] = ad[64];
                                    accum_next = ad[63:0];
                                    mode_next = M_INT;
                                end else if (src_byte == CH_GT) begin
                                    go = 1'b0;
                                    batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_ARROW,
                                        pos32(start_next), 32'd2, line32(tline_next), '0, '0, 1'b0);
                                    batch.count = batch.count + 1'b1;
                                    mode_next = M_IDLE;
                                end else begin
                                    mode_next = M_WORD;
                                end
                            end
                            M_WORD: begin
                                if (!is_stop(src_byte)) begin
                                    go = 1'b0;
                                end else begin
                                    batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_WORD,
                                        pos32(start_next), pos32(p - start_next),
                                        line32(tline_next), '0, '0, 1'b0);
                                    batch.count = batch.count + 1'b1;
                                    mode_next = M_IDLE;
                                end
                            end
                            M_INT, M_FRAC, M_EXPD: begin
                                if (is_digit(src_byte)) begin
                                    go = 1'b0;
                                    if (mode_next == M_INT) begin
                                        ad = add_digit(accum_next, flags_next[F_NEG],
                                                       flags_next[F_OVF], src_byte);
                                        flags_next[F_OVF] = ad[64];
                                        accum_next = ad[63:0];
                                    end
                                end else if (mode_next == M_INT && src_byte == CH_DOT) begin
                                    go = 1'b0;
                                    flags_next[F_FRAC] = 1'b1;
                                    mode_next = M_FRAC;
                                end else if (mode_next != M_EXPD &&
                                             (src_byte == CH_LOW_E || src_byte == CH_UP_E)) begin
                                    go = 1'b0;
                                    held_next = 2'd1;
                                    mode_next = M_EXP0;
                                end else begin
                                    len = p - start_next;
                                    if (flags_next[F_OVF] || flags_next[F_FRAC] ||
                                        flags_next[F_EXP]) begin
                                        batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_FLOAT,
                                            pos32(start_next), pos32(len), line32(tline_next),
                                            '0, '0, 1'b0);
                                    end else begin
                                        batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_INT,
                                            pos32(start_next), pos32(len), line32(tline_next),
                                            flags_next[F_NEG] ? 64'd0 - accum_next : accum_next,
                                            '0, 1'b0);
                                    end
                                    batch.count = batch.count + 1'b1;
                                    mode_next = M_IDLE;
                                end
                            end
                            M_EXP0, M_EXP1: begin
                                // the give-back case is handled ahead of the passes
                                go = 1'b0;
                                if (is_digit(src_byte)) begin
                                    flags_next[F_EXP] = 1'b1;
                                    held_next = '0;
                                    mode_next = M_EXPD;
                                end else begin
                                    held_next = 2'd2;
                                    mode_next = M_EXP1;
                                end
                            end
                            M_STR: begin
                                go = 1'b0;
                                if (src_byte == CH_QUOTE) begin
                                    batch.res[batch.count[1:0]] = mk(KIND_TOKEN, T_STRING,
                                        pos32(start_next), pos32(p - start_next),
                                        line32(tline_next), '0, '0, 1'b0);
                                    batch.count = batch.count + 1'b1;
                                    mode_next = M_IDLE;
                                end else if (src_byte == CH_BSLASH) begin
                                    mode_next = M_ESC;
                                end else begin
                                    batch.res[batch.count[1:0]] = mk(KIND_CHAR, T_STRING,
                                        pos32(start_next), '0, line32(tline_next), '0,
                                        src_byte, 1'b0);
                                    batch.count = batch.count + 1'b1;
                                end
                            end
                            M_ESC: begin
                                go = 1'b0;
                                ch_ok = 1'b1;
                                case (src_byte)
                                    CH_LOW_N: ch = CH_LF;
                                    CH_LOW_T: ch = CH_TAB;
                                    CH_LOW_R: ch = CH_CR;
                                    CH_BSLASH: ch = CH_BSLASH;
                                    CH_QUOTE: ch = CH_QUOTE;
                                    CH_ZERO: ch = 8'd0;
                                    default: ch_ok = 1'b0;
                                endcase
                                if (ch_ok) begin
                                    batch.res[batch.count[1:0]] = mk(KIND_CHAR, T_STRING,
                                        pos32(start_next), '0, line32(tline_next), '0, ch, 1'b0);
                                    mode_next = M_STR;
                                end else begin
                                    batch.res[batch.count[1:0]] = mk(KIND_ERROR, T_STRING,
                                        pos32(start_next), '0, line32(tline_next), '0, '0,
                                        ERR_ESCAPE);
                                    halted_next = 1'b1;
                                end
                                batch.count = batch.count + 1'b1;
                            end
                            default: begin
                                mode_next = M_IDLE;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            start_reg  <= '0;
            tline_reg  <= LINE_BITS'(1);
            accum_reg  <= '0;
            flags_reg  <= '0;
            held_reg   <= '0;
            halted_reg <= 1'b0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            start_reg  <= start_next;
            tline_reg  <= tline_next;
            accum_reg  <= accum_next;
            flags_reg  <= flags_next;
            held_reg   <= held_next;
            halted_reg <= halted_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/stt_result_buf.sv
// stt_result_buf: result register that holds one item's results and sends them in order
// depends on stt_pkg
`default_nettype none

module stt_result_buf
    import stt_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          load,
    input  batch_t             batch,
    output logic               can_load,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [175:0]       m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    result_t [MAX_RES-1:0] res_reg;
    logic [2:0]            count_reg;
    logic [1:0]            head_reg;
    result_t               cur;

    assign cur      = res_reg[head_reg];
    assign m_tvalid = count_reg != 3'd0;
    assign can_load = count_reg == 3'd0 || (count_reg == 3'd1 && m_tready);
    assign m_tuser  = cur.kind;
    assign m_tlast  = count_reg == 3'd1;
    assign m_tdata  = {3'b000, cur.error_code, cur.char_value, cur.int_value,
                       cur.token_line, cur.token_length, cur.token_start, cur.token_type};

    // load a new batch or step to the next result on each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
        end else if (load) begin
            count_reg <= batch.count;
            head_reg  <= '0;
        end else if (m_tvalid && m_tready) begin
            count_reg <= count_reg - 1'b1;
            head_reg  <= head_reg + 1'b1;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= batch.res;
        end
    end

endmodule

`default_nettype wire
